// ===== sv/acl_pkg.sv =====
// ----------------------------------------------------------------------------
// acl_pkg: AT response line classifier package
// Payload types, awaited-state codes, character codes and prefix tokens.
// ----------------------------------------------------------------------------
package acl_pkg;

    localparam int ACL_LEN_W  = 10;
    localparam int ACL_POS_W  = 9;
    localparam int ACL_TEXT_W = 8;

    // upper bound of the text limit; a line length clamped here keeps min() exact
    localparam int ACL_TEXT_CAP   = 1024;
    localparam int ACL_TEXT_CAP_W = 11;

    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_MODE   = 3'd2;
    localparam logic [2:0] ST_PROMPT = 3'd3;
    localparam logic [2:0] ST_SEND   = 3'd4;
    localparam logic [2:0] ST_LIST   = 3'd5;
    localparam logic [2:0] ST_PIN    = 3'd6;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    localparam int TK_OK_LEN  = 2;
    localparam int TK_ERR_LEN = 11;
    localparam int TK_ENT_LEN = 6;
    localparam int TK_NTF_LEN = 7;

    localparam logic [0:TK_OK_LEN-1][7:0]  TK_OK  = "OK";
    localparam logic [0:TK_ERR_LEN-1][7:0] TK_ERR = "+CME ERROR:";
    localparam logic [0:TK_ENT_LEN-1][7:0] TK_ENT = "+CMGL:";
    localparam logic [0:TK_NTF_LEN-1][7:0] TK_NTF = "+CMTI: ";

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
        logic [2:0] expect_state;
    } acl_item_t;

    typedef struct packed {
        logic [ACL_LEN_W-1:0]  line_length;
        logic                  command_done;
        logic                  command_failed;
        logic                  entry_header;
        logic [ACL_POS_W-1:0]  number_offset;
        logic [ACL_TEXT_W-1:0] text_accepted;
        logic                  notify;
        logic [ACL_POS_W-1:0]  notify_index_offset;
        logic [ACL_POS_W-1:0]  notify_index_length;
        logic [2:0]            waiting_after;
    } acl_result_t;

    // classified line passed from the front to the back
    typedef struct packed {
        logic [ACL_LEN_W-1:0]      line_length;
        logic                      command_done;
        logic                      command_failed;
        logic                      entry_header;
        logic [ACL_POS_W-1:0]      number_offset;
        logic                      notify;
        logic [ACL_POS_W-1:0]      notify_index_offset;
        logic [ACL_POS_W-1:0]      notify_index_length;
        logic [2:0]                waiting_after;
        logic                      text_line;
        logic [ACL_TEXT_CAP_W-1:0] text_len;
    } acl_line_t;

endpackage

// ===== sv/acl_front.sv =====
// ----------------------------------------------------------------------------
// acl_front: line assembly and classification
// Accepts bytes and host commands, tracks prefixes and commas, and on line end
// classifies the line against the awaited response.
// ----------------------------------------------------------------------------
module acl_front #(
    parameter int LINE_MAX   = 512,
    parameter int NUMBER_LEN = 12
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  acl_pkg::acl_item_t item,
    input  logic              cfg_we,
    input  logic              cfg_data,
    output logic              push,
    output acl_pkg::acl_line_t line
);
    import acl_pkg::*;

    localparam int LW = $clog2(LINE_MAX + 1);
    localparam int CW = LW + 7;

    logic          notify_enable_reg;
    logic [2:0]    ws_reg, ws_next;
    logic [LW-1:0] lc_reg, lc_next;
    logic          fs_reg, fs_next;
    logic [LW-1:0] fp_reg, fp_next;
    logic          ss_reg, ss_next;
    logic [LW-1:0] sp_reg, sp_next;
    logic          q_reg, q_next;
    logic [3:0]    pf_reg, pf_next;

    logic          do_app, gt_prompt, end_line;
    logic [LW-1:0] p, n;
    logic [3:0]    mism;
    logic          is_ok, is_err, is_ent, is_ntf, first_ok, ent_ok, ntf;
    logic [2:0]    ws_mid, wait_after;
    logic          done, failed, entry, text_line;
    logic [LW-1:0] noff;

    always_comb
    begin
        gt_prompt = !item.kind && item.rx_byte == CH_GT && ws_reg == ST_PROMPT;
        do_app = !item.kind && item.rx_byte != CH_CR && item.rx_byte != CH_LF
                 && (item.rx_byte != CH_GT || ws_reg == ST_PROMPT);
        p = lc_reg;
        fs_next = fs_reg;
        fp_next = fp_reg;
        ss_next = ss_reg;
        sp_next = sp_reg;
        q_next  = q_reg;
        lc_next = lc_reg;
        mism = 4'b0000;
        if (do_app)
        begin
            if (p < LW'(TK_OK_LEN) && TK_OK[p[0]] != item.rx_byte)
                mism[0] = 1'b1;
            if (p < LW'(TK_ERR_LEN) && TK_ERR[p[3:0]] != item.rx_byte)
                mism[1] = 1'b1;
            if (p < LW'(TK_ENT_LEN) && TK_ENT[p[2:0]] != item.rx_byte)
                mism[2] = 1'b1;
            if (p < LW'(TK_NTF_LEN) && TK_NTF[p[2:0]] != item.rx_byte)
                mism[3] = 1'b1;
            if (item.rx_byte == CH_COMMA)
            begin
                if (!fs_reg)
                begin
                    fs_next = 1'b1;
                    fp_next = p;
                end
                else if (!ss_reg)
                begin
                    ss_next = 1'b1;
                    sp_next = p;
                end
            end
            if (ss_next && CW'(p) == CW'(sp_next) + CW'(1) && item.rx_byte == CH_QUOTE)
                q_next = 1'b1;
            lc_next = lc_reg + LW'(1);
        end
        pf_next = pf_reg & ~mism;
        n = lc_next;
        end_line = !item.kind && (item.rx_byte == CH_CR || gt_prompt
                   || (do_app && CW'(lc_next) >= CW'(LINE_MAX)));

        is_ok  = pf_next[0] && n == LW'(TK_OK_LEN);
        is_err = pf_next[1] && n >= LW'(TK_ERR_LEN);
        is_ent = pf_next[2] && n >= LW'(TK_ENT_LEN);
        is_ntf = pf_next[3] && n > LW'(TK_NTF_LEN);
        first_ok = fs_next && (CW'(fp_next) + CW'(1) < CW'(n));
        ent_ok = first_ok && ss_next && q_next
                 && (CW'(sp_next) + CW'(NUMBER_LEN) + CW'(3) < CW'(n));
        ntf = is_ntf && notify_enable_reg && first_ok;
        noff = fp_next + LW'(1);
        ws_mid = ntf ? ST_IDLE : ws_reg;

        done = ntf;
        failed = 1'b0;
        entry = 1'b0;
        text_line = 1'b0;
        unique case (ws_mid)
            ST_INIT, ST_MODE, ST_SEND, ST_PIN:
            begin
                if (is_ok || is_err)
                begin
                    done = 1'b1;
                    failed = !is_ok;
                end
            end
            ST_PROMPT:
            begin
                if (gt_prompt && n == LW'(1))
                    done = 1'b1;
                else if (is_err)
                begin
                    done = 1'b1;
                    failed = 1'b1;
                end
            end
            ST_LIST:
            begin
                if (is_ok || is_err)
                begin
                    done = 1'b1;
                    failed = !is_ok;
                end
                else if (is_ent)
                    entry = ent_ok;
                else
                    text_line = 1'b1;
            end
            default:
            begin
                done = done;
            end
        endcase
        wait_after = done ? ST_IDLE : ws_mid;

        line.line_length         = ACL_LEN_W'(n);
        line.command_done        = done;
        line.command_failed      = failed;
        line.entry_header        = entry;
        line.number_offset       = entry ? ACL_POS_W'(sp_next + LW'(2)) : '0;
        line.notify              = ntf;
        line.notify_index_offset = ntf ? ACL_POS_W'(noff) : '0;
        line.notify_index_length = ntf ? ACL_POS_W'(n - noff) : '0;
        line.waiting_after       = wait_after;
        line.text_line           = text_line;
        line.text_len            = (CW'(n) > CW'(ACL_TEXT_CAP))
                                   ? ACL_TEXT_CAP_W'(ACL_TEXT_CAP) : ACL_TEXT_CAP_W'(n);

        push = accept && end_line;
        ws_next = ws_reg;
        if (accept && item.kind)
            ws_next = item.expect_state;
        else if (push)
            ws_next = wait_after;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            notify_enable_reg <= 1'b0;
            ws_reg <= ST_INIT;
            lc_reg <= '0;
            fs_reg <= 1'b0;
            fp_reg <= '0;
            ss_reg <= 1'b0;
            sp_reg <= '0;
            q_reg  <= 1'b0;
            pf_reg <= 4'b1111;
        end
        else
        begin
            if (cfg_we)
                notify_enable_reg <= cfg_data;
            ws_reg <= ws_next;
            if (push)
            begin
                lc_reg <= '0;
                fs_reg <= 1'b0;
                fp_reg <= '0;
                ss_reg <= 1'b0;
                sp_reg <= '0;
                q_reg  <= 1'b0;
                pf_reg <= 4'b1111;
            end
            else if (accept && do_app)
            begin
                lc_reg <= lc_next;
                fs_reg <= fs_next;
                fp_reg <= fp_next;
                ss_reg <= ss_next;
                sp_reg <= sp_next;
                q_reg  <= q_next;
                pf_reg <= pf_next;
            end
        end
    end

endmodule

// ===== sv/acl_fifo.sv =====
// ----------------------------------------------------------------------------
// acl_fifo: two-entry line queue
// Decouples the classifying front from the message back.
// ----------------------------------------------------------------------------
module acl_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  acl_pkg::acl_line_t push_data,
    output logic               full,
    input  logic               pop,
    output acl_pkg::acl_line_t pop_data,
    output logic               empty
);
    import acl_pkg::*;

    acl_line_t  mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign full     = count_reg == 2'd2;
    assign empty    = count_reg == 2'd0;
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

endmodule

// ===== sv/acl_back.sv =====
// ----------------------------------------------------------------------------
// acl_back: message text accounting and result register
// Tracks the open message and its text length; drives the result channel.
// ----------------------------------------------------------------------------
module acl_back #(
    parameter int TEXT_MAX = 160
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 empty,
    input  acl_pkg::acl_line_t   line,
    output logic                 pop,
    output logic                 result_valid,
    input  logic                 result_stall,
    output acl_pkg::acl_result_t result
);
    import acl_pkg::*;

    localparam int TW = $clog2(TEXT_MAX + 1);
    localparam int AW = (TW > ACL_TEXT_CAP_W) ? TW : ACL_TEXT_CAP_W;

    logic          open_reg;
    logic [TW-1:0] tlen_reg;
    logic          valid_reg;
    acl_result_t   result_reg, result_next;
    logic [AW-1:0] room, acc;

    assign pop          = !empty && (!valid_reg || !result_stall);
    assign result_valid = valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        room = AW'(TEXT_MAX) - AW'(tlen_reg);
        acc  = '0;
        if (line.text_line && open_reg)
            acc = (AW'(line.text_len) < room) ? AW'(line.text_len) : room;
        result_next.line_length         = line.line_length;
        result_next.command_done        = line.command_done;
        result_next.command_failed      = line.command_failed;
        result_next.entry_header        = line.entry_header;
        result_next.number_offset       = line.number_offset;
        result_next.text_accepted       = ACL_TEXT_W'(acc);
        result_next.notify              = line.notify;
        result_next.notify_index_offset = line.notify_index_offset;
        result_next.notify_index_length = line.notify_index_length;
        result_next.waiting_after       = line.waiting_after;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg  <= 1'b0;
            tlen_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
                valid_reg <= 1'b1;
            else if (!result_stall)
                valid_reg <= 1'b0;
            if (pop && line.entry_header)
            begin
                open_reg <= 1'b1;
                tlen_reg <= '0;
            end
            else if (pop)
                tlen_reg <= tlen_reg + TW'(acc);
        end
    end

endmodule

// ===== sv/at_response_line_classifier_top.sv =====
// ----------------------------------------------------------------------------
// at_response_line_classifier_top: AT response line classifier
// Assembles modem receive bytes into lines and reports one result per line.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid / item_stall / item): a received byte (kind 0)
//   or a host command (kind 1) that sets the awaited response state.
//   result channel (result_valid / result_stall / result): one transaction per
//   completed line (carriage return, line limit, or '>' while a prompt is
//   awaited). Line feeds and host commands give no result.
//   cfg channel (cfg_valid / cfg_ready / cfg_data): notify_enable, always ready;
//   write it only while no line is in flight.
// Timing: one item per cycle while item_stall is low. A line-ending byte's result
//   is classified in the front, passes the two-entry queue and is registered in
//   the back. Line state is tracked byte by byte in the front.
// Stall: when result_stall holds, the result register keeps its transaction,
//   the queue fills and item_stall rises once it holds two lines.
// Reset: awaited state init, no open message, empty line, notify disabled.
// ----------------------------------------------------------------------------
module at_response_line_classifier_top #(
    parameter int LINE_MAX   = 512,
    parameter int TEXT_MAX   = 160,
    parameter int NUMBER_LEN = 12
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  acl_pkg::acl_item_t   item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output acl_pkg::acl_result_t result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data
);
    import acl_pkg::*;

    logic      accept, push, full, pop, empty;
    acl_line_t push_line, pop_line;

    assign cfg_ready  = 1'b1;
    assign item_stall = full;
    assign accept     = item_valid && !full;

    acl_front #(
        .LINE_MAX   (LINE_MAX),
        .NUMBER_LEN (NUMBER_LEN)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .push     (push),
        .line     (push_line)
    );

    acl_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_line),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_line),
        .empty     (empty)
    );

    acl_back #(
        .TEXT_MAX (TEXT_MAX)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (empty),
        .line         (pop_line),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    a_fail_done: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.command_failed |-> result.command_done)
        else $error("failed line without completion");

    a_notify_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.notify |->
            result.command_done && result.waiting_after == ST_IDLE)
        else $error("notification did not return to idle");

    a_entry_text: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.entry_header |-> result.text_accepted == '0)
        else $error("header line appended text");

    a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("line pushed into full queue");

endmodule

// ===== bench/tb_at_response_line_classifier_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_at_response_line_classifier_top: AT response line classifier testbench
// Drives modem bytes and host commands, predicts each completed line in a
// scoreboard of its own and checks every result transaction field by field.
// Runs directed lines, then three random phases with varied idling and
// notify_enable settings.
// ----------------------------------------------------------------------------
module tb_at_response_line_classifier_top;

    import acl_pkg::*;

    localparam int LINE_MAX     = 512;
    localparam int TEXT_MAX     = 160;
    localparam int NUMBER_LEN   = 12;
    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_CMD   = 1'b1;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int SETTLE_CYC   = 8;

    class line_tracker;
        acl_result_t expected_lines[$];
        int unsigned errors;
        bit          notify_en;
        logic [2:0]  waiting;
        int unsigned line_count;
        bit          first_seen;
        int unsigned first_pos;
        bit          second_seen;
        int unsigned second_pos;
        bit          quote_after_second;
        bit [3:0]    prefix_live;
        bit          msg_open;
        int unsigned text_len;

        function new();
            errors    = 0;
            notify_en = 1'b0;
            waiting   = ST_INIT;
            msg_open  = 1'b0;
            text_len  = 0;
            clear_line();
        endfunction

        function void clear_line();
            line_count         = 0;
            first_seen         = 1'b0;
            first_pos          = 0;
            second_seen        = 1'b0;
            second_pos         = 0;
            quote_after_second = 1'b0;
            prefix_live        = 4'hF;
        endfunction

        function void add_char(logic [7:0] c);
            int unsigned p;
            p = line_count;
            if (p < TK_OK_LEN && TK_OK[p] != c)
                prefix_live[0] = 1'b0;
            if (p < TK_ERR_LEN && TK_ERR[p] != c)
                prefix_live[1] = 1'b0;
            if (p < TK_ENT_LEN && TK_ENT[p] != c)
                prefix_live[2] = 1'b0;
            if (p < TK_NTF_LEN && TK_NTF[p] != c)
                prefix_live[3] = 1'b0;
            if (c == CH_COMMA)
            begin
                if (!first_seen)
                begin
                    first_seen = 1'b1;
                    first_pos  = p;
                end
                else if (!second_seen)
                begin
                    second_seen = 1'b1;
                    second_pos  = p;
                end
            end
            if (second_seen && p == second_pos + 1 && c == CH_QUOTE)
                quote_after_second = 1'b1;
            line_count++;
        endfunction

        function acl_result_t close_line(bit prompt);
            acl_result_t r;
            int unsigned n;
            int unsigned room;
            int unsigned acc;
            bit is_ok;
            bit is_err;
            bit is_ent;
            bit is_ntf;
            n      = line_count;
            is_ok  = prefix_live[0] && n == TK_OK_LEN;
            is_err = prefix_live[1] && n >= TK_ERR_LEN;
            is_ent = prefix_live[2] && n >= TK_ENT_LEN;
            is_ntf = prefix_live[3] && n > TK_NTF_LEN;
            r = '0;
            if (is_ntf && notify_en && first_seen && first_pos + 1 < n)
            begin
                r.notify              = 1'b1;
                r.notify_index_offset = ACL_POS_W'(first_pos + 1);
                r.notify_index_length = ACL_POS_W'(n - (first_pos + 1));
                r.command_done        = 1'b1;
                waiting               = ST_IDLE;
            end
            case (waiting)
                ST_INIT, ST_MODE, ST_SEND, ST_PIN:
                begin
                    if (is_ok || is_err)
                    begin
                        r.command_done   = 1'b1;
                        r.command_failed = !is_ok;
                        waiting          = ST_IDLE;
                    end
                end
                ST_PROMPT:
                begin
                    if ((prompt && n == 1) || is_err)
                    begin
                        r.command_done   = 1'b1;
                        r.command_failed = !(prompt && n == 1);
                        waiting          = ST_IDLE;
                    end
                end
                ST_LIST:
                begin
                    if (is_ok || is_err)
                    begin
                        r.command_done   = 1'b1;
                        r.command_failed = !is_ok;
                        waiting          = ST_IDLE;
                    end
                    else if (is_ent)
                    begin
                        if (first_seen && first_pos + 1 < n && second_seen &&
                            second_pos + NUMBER_LEN + 3 < n && quote_after_second)
                        begin
                            r.entry_header  = 1'b1;
                            r.number_offset = ACL_POS_W'(second_pos + 2);
                            msg_open        = 1'b1;
                            text_len        = 0;
                        end
                    end
                    else if (msg_open)
                    begin
                        room = (text_len < TEXT_MAX) ? TEXT_MAX - text_len : 0;
                        acc  = (n < room) ? n : room;
                        text_len += acc;
                        r.text_accepted = ACL_TEXT_W'(acc);
                    end
                end
                default:
                begin
                end
            endcase
            r.line_length   = ACL_LEN_W'(n);
            r.waiting_after = waiting;
            clear_line();
            return r;
        endfunction

        function void note_item(acl_item_t it);
            logic [7:0] c;
            c = it.rx_byte;
            if (it.kind == KIND_CMD)
                waiting = it.expect_state;
            else if (c == CH_CR)
                expected_lines.push_back(close_line(1'b0));
            else if (c == CH_GT)
            begin
                if (waiting == ST_PROMPT)
                begin
                    add_char(c);
                    expected_lines.push_back(close_line(1'b1));
                end
            end
            else if (c != CH_LF)
            begin
                add_char(c);
                if (line_count >= LINE_MAX)
                    expected_lines.push_back(close_line(1'b0));
            end
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
            end
        endfunction

        function void check_line(acl_result_t got);
            acl_result_t want;
            if (expected_lines.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual length %0d",
                         $time, got.line_length);
                return;
            end
            want = expected_lines.pop_front();
            compare_field("line_length", want.line_length, got.line_length);
            compare_field("command_done", want.command_done, got.command_done);
            compare_field("command_failed", want.command_failed, got.command_failed);
            compare_field("entry_header", want.entry_header, got.entry_header);
            compare_field("number_offset", want.number_offset, got.number_offset);
            compare_field("text_accepted", want.text_accepted, got.text_accepted);
            compare_field("notify", want.notify, got.notify);
            compare_field("notify_index_offset", want.notify_index_offset,
                          got.notify_index_offset);
            compare_field("notify_index_length", want.notify_index_length,
                          got.notify_index_length);
            compare_field("waiting_after", want.waiting_after, got.waiting_after);
        endfunction
    endclass

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        item_valid   = 1'b0;
    logic        item_stall;
    acl_item_t   item         = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    acl_result_t result;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    logic        cfg_data     = 1'b0;

    line_tracker tracker        = new();
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned items_sent     = 0;
    string       prefix_tokens[4] = '{"OK", "+CME ERROR:", "+CMGL:", "+CMTI: "};
    int unsigned send_idle_tab[3]  = '{20, 46, 0};
    int unsigned recv_stall_tab[3] = '{46, 20, 0};
    bit          notify_tab[3]     = '{1'b1, 1'b0, 1'b1};
    int unsigned phase_items[3]    = '{150, 150, 530};

    at_response_line_classifier_top #(
        .LINE_MAX   (LINE_MAX),
        .TEXT_MAX   (TEXT_MAX),
        .NUMBER_LEN (NUMBER_LEN)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            tracker.check_line(result);
        result_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic push_item(input acl_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (item_stall);
        tracker.note_item(it);
        items_sent++;
    endtask

    task automatic push_byte(input logic [7:0] b);
        acl_item_t it;
        it.kind         = KIND_BYTE;
        it.rx_byte      = b;
        it.expect_state = 3'($urandom_range(7));
        push_item(it);
    endtask

    task automatic issue(input logic [2:0] st);
        acl_item_t it;
        it.kind         = KIND_CMD;
        it.rx_byte      = 8'($urandom_range(255));
        it.expect_state = st;
        push_item(it);
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    task automatic send_rand(input int unsigned n, input logic [7:0] lo, input logic [7:0] hi);
        repeat (n)
            push_byte(8'($urandom_range(hi, lo)));
    endtask

    task automatic end_line();
        push_byte(CH_CR);
        if ($urandom_range(1) != 0)
            push_byte(CH_LF);
    endtask

    task automatic settle();
        int unsigned waited;
        waited     = 0;
        item_valid <= 1'b0;
        while (tracker.expected_lines.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_notify_enable(input bit v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        tracker.notify_en = v;
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int unsigned ep;
        int unsigned r;
        int unsigned v;
        int unsigned target;
        string       s;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_notify_enable(1'b0);

        // directed lines
        issue(ST_INIT);
        send_str("OK");
        end_line();
        issue(ST_LIST);
        send_str("abc");
        end_line();
        send_str("+CMGL: 1,\"REC READ\",\"+441234567890\",,\"x\"");
        end_line();
        send_str("hello");
        end_line();
        push_byte(8'h00);
        push_byte(8'hFF);
        end_line();
        send_str("+CMTI: \"SM\",3");
        end_line();
        send_str("+CMGL: 2,\"REC\",\"+4412345678\"");
        end_line();
        send_str("+CMGL: 3,\"REC\"\"+441234567890\",x");
        end_line();
        send_str("OK");
        end_line();
        issue(ST_MODE);
        send_str("+CME ERROR: 3");
        end_line();
        issue(ST_PROMPT);
        push_byte(CH_GT);
        issue(ST_IDLE);
        push_byte(CH_GT);
        end_line();
        send_str("OK");
        end_line();
        issue(3'd7);
        send_str("OK");
        end_line();
        settle();
        write_notify_enable(1'b1);
        send_str("+CMTI: \"SM\"");
        end_line();
        send_str("+CMTI: \"SM\",");
        end_line();
        send_str("+CMTI: \"SM\",12");
        end_line();

        for (int ph = 0; ph < 3; ph++)
        begin
            settle();
            write_notify_enable(notify_tab[ph]);
            send_idle_pct  = send_idle_tab[ph];
            recv_stall_pct = recv_stall_tab[ph];
            target         = items_sent + phase_items[ph];
            if (ph == 2)
            begin
                send_rand(LINE_MAX, "a", "z");
                end_line();
            end
            while (items_sent < target)
            begin
                ep = $urandom_range(99);
                if (ep < 35)
                begin
                    issue(ST_LIST);
                    repeat ($urandom_range(1, 3))
                    begin
                        send_str("+CMGL: ");
                        send_rand($urandom_range(1, 3), "0", "9");
                        v = $urandom_range(9);
                        if (v != 0)
                        begin
                            push_byte(CH_COMMA);
                            if (v != 1)
                            begin
                                send_str("\"REC READ\",");
                                if (v != 2)
                                    push_byte(CH_QUOTE);
                                send_rand($urandom_range(10, 13), "0", "9");
                                push_byte(CH_QUOTE);
                                send_rand($urandom_range(0, 6), 8'h20, 8'h7E);
                            end
                        end
                        end_line();
                        repeat ($urandom_range(0, 4))
                        begin
                            if ($urandom_range(19) == 0)
                                send_rand($urandom_range(100, 200), 8'h20, 8'h7E);
                            else
                                send_rand($urandom_range(0, 40), 8'h20, 8'h7E);
                            end_line();
                        end
                    end
                    r = $urandom_range(9);
                    if (r < 6)
                    begin
                        send_str("OK");
                        end_line();
                    end
                    else if (r < 8)
                    begin
                        send_str("+CME ERROR: ");
                        send_rand($urandom_range(1, 3), "0", "9");
                        end_line();
                    end
                end
                else if (ep < 55)
                begin
                    issue(3'($urandom_range(7)));
                    if ($urandom_range(9) < 3)
                    begin
                        send_rand($urandom_range(0, 20), 8'h20, 8'h7E);
                        end_line();
                    end
                    r = $urandom_range(9);
                    if (r < 6)
                        send_str("OK");
                    else if (r < 8)
                    begin
                        send_str("+CME ERROR:");
                        send_rand($urandom_range(0, 4), 8'h20, 8'h7E);
                    end
                    else
                    begin
                        s = prefix_tokens[$urandom_range(3)];
                        s[$urandom_range(s.len() - 1)] = 8'($urandom_range(8'h7E, 8'h21));
                        send_str(s);
                    end
                    end_line();
                end
                else if (ep < 70)
                begin
                    issue(ST_PROMPT);
                    if ($urandom_range(9) < 3)
                    begin
                        send_rand($urandom_range(0, 20), 8'h20, 8'h7E);
                        end_line();
                    end
                    r = $urandom_range(9);
                    if (r < 7)
                    begin
                        if ($urandom_range(4) == 0)
                            send_rand($urandom_range(1, 3), "a", "z");
                        push_byte(CH_GT);
                    end
                    else
                    begin
                        if (r < 9)
                            send_str("+CME ERROR: 1");
                        else
                            send_str("OK");
                        end_line();
                    end
                end
                else if (ep < 82)
                begin
                    if ($urandom_range(4) == 0)
                        issue(3'($urandom_range(7)));
                    send_str(($urandom_range(1) != 0) ? "+CMTI: \"SM\"" : "+CMTI: \"ME\"");
                    v = $urandom_range(5);
                    if (v != 0)
                        push_byte(CH_COMMA);
                    if (v > 1)
                        send_rand($urandom_range(1, 3), "0", "9");
                    end_line();
                end
                else
                begin
                    r = $urandom_range(9);
                    if (r < 5)
                        send_rand($urandom_range(1, 12), 8'h00, 8'hFF);
                    else
                    begin
                        s = prefix_tokens[$urandom_range(3)];
                        if (r < 7)
                            s = s.substr(0, $urandom_range(s.len() - 1));
                        else
                            s[$urandom_range(s.len() - 1)] = 8'($urandom_range(8'h7E, 8'h21));
                        send_str(s);
                        send_rand($urandom_range(0, 4), 8'h20, 8'h7E);
                    end
                    end_line();
                end
            end
            end_line();
        end

        settle();
        if (tracker.expected_lines.size() != 0)
            $display("%0t: %0d result lines never arrived", $time,
                     tracker.expected_lines.size());
        if (tracker.errors == 0 && tracker.expected_lines.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
